>>> hdl/rau_pkg.sv
// Shared constants, action codes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

  localparam int WORD_WIDTH_DEF = 32;
  localparam int FIELD_W        = 32;
  localparam int ACT_W          = 4;

  // 10000 in binary, scanned MSB first by the scale step
  localparam int             EQ_BITS  = 14;
  localparam logic [13:0]    EQ_SCALE = 14'd10000;
  localparam int             SIDX_W   = 4;

  localparam logic [3:0] ACT_ADD  = 4'd0;
  localparam logic [3:0] ACT_SUB  = 4'd1;
  localparam logic [3:0] ACT_NEG  = 4'd2;
  localparam logic [3:0] ACT_MUL  = 4'd3;
  localparam logic [3:0] ACT_DIV  = 4'd4;
  localparam logic [3:0] ACT_SIMP = 4'd5;
  localparam logic [3:0] ACT_EQ   = 4'd6;
  localparam logic [3:0] ACT_NE   = 4'd7;
  localparam logic [3:0] ACT_LT   = 4'd8;
  localparam logic [3:0] ACT_LE   = 4'd9;
  localparam logic [3:0] ACT_GT   = 4'd10;
  localparam logic [3:0] ACT_GE   = 4'd11;

  localparam logic [1:0] MSEL_AD = 2'd0;
  localparam logic [1:0] MSEL_BC = 2'd1;
  localparam logic [1:0] MSEL_AC = 2'd2;
  localparam logic [1:0] MSEL_BD = 2'd3;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL,
    OP_DIFF,
    OP_SCALE,
    OP_GINIT,
    OP_GSTEP,
    OP_DIV_LOAD_N,
    OP_DIV_LOAD_D,
    OP_DIV_STEP,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [1:0]        mul_sel;
    logic [SIDX_W-1:0] scale_bit;
  } dp_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             a_zero;
    logic             b_zero;
    logic             gcd_eq;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> hdl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: controller plus datapath.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_stall | in_action, in_a_num, in_a_den,
//           |                     | in_b_num, in_b_den
//  result   | out_valid/out_stall | out_res_num, out_res_den,
//           |                     | out_compare_true, out_zero_den
//
// Sequencing: one item at a time. Add, sub, neg, mul, div, lt, le, gt and ge run
//   load, four products on one shared multiplier, difference and finish. Eq and
//   ne add a bit-serial scale by 10000 before the finish step.
// Simplify with two nonzero parts runs the binary gcd steps, followed by two
//   passes of the one-bit-per-cycle restoring divider.
// Reset: rst_n is synchronous, active low, and clears controller state only.
// Stalls: a finished item sits in the output register while the next item is
//   accepted and worked on; the finish step waits only if that register is
//   still held by out_stall.
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit #(
  parameter int WORD_WIDTH = rau_pkg::WORD_WIDTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire [rau_pkg::ACT_W-1:0]             in_action,
  input  wire signed [rau_pkg::FIELD_W-1:0]    in_a_num,
  input  wire signed [rau_pkg::FIELD_W-1:0]    in_a_den,
  input  wire signed [rau_pkg::FIELD_W-1:0]    in_b_num,
  input  wire signed [rau_pkg::FIELD_W-1:0]    in_b_den,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [rau_pkg::FIELD_W-1:0]   out_res_num,
  output logic signed [rau_pkg::FIELD_W-1:0]   out_res_den,
  output logic                                 out_compare_true,
  output logic                                 out_zero_den
);

  rau_pkg::dp_cmd_t  cmd;
  rau_pkg::dp_stat_t stat;

  // sequencing: one command per cycle to the datapath
  rau_ctrl #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // operands, products, gcd/divider and the output register
  rau_dp #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_action        (in_action),
    .in_a_num         (in_a_num),
    .in_a_den         (in_a_den),
    .in_b_num         (in_b_num),
    .in_b_den         (in_b_den),
    .out_res_num      (out_res_num),
    .out_res_den      (out_res_den),
    .out_compare_true (out_compare_true),
    .out_zero_den     (out_zero_den)
  );

endmodule
`default_nettype wire

>>> hdl/rau_dp.sv
// Datapath: operand and product registers, scale accumulator, binary gcd, divider.
`timescale 1ns / 1ps
`default_nettype none
module rau_dp #(
  parameter int WORD_WIDTH = rau_pkg::WORD_WIDTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  rau_pkg::dp_cmd_t                     cmd,
  output rau_pkg::dp_stat_t                    stat,
  input  wire [rau_pkg::ACT_W-1:0]             in_action,
  input  wire signed [rau_pkg::FIELD_W-1:0]    in_a_num,
  input  wire signed [rau_pkg::FIELD_W-1:0]    in_a_den,
  input  wire signed [rau_pkg::FIELD_W-1:0]    in_b_num,
  input  wire signed [rau_pkg::FIELD_W-1:0]    in_b_den,
  output logic signed [rau_pkg::FIELD_W-1:0]   out_res_num,
  output logic signed [rau_pkg::FIELD_W-1:0]   out_res_den,
  output logic                                 out_compare_true,
  output logic                                 out_zero_den
);

  localparam int W  = WORD_WIDTH;
  localparam int PW = 2 * W;
  localparam int KW = $clog2(W);
  localparam int AW = PW + 1 + rau_pkg::EQ_BITS;

  logic [rau_pkg::ACT_W-1:0] act_r;
  logic signed [W-1:0]       a_r, b_r, c_r, d_r;
  logic signed [PW-1:0]      p_ad_r, p_bc_r, p_ac_r, p_bd_r;
  logic signed [PW:0]        diff_r;
  logic [AW-1:0]             acc_r;
  logic [W-1:0]              x_r, y_r, q_r, qn_r;
  logic [W:0]                rem_r;
  logic [KW-1:0]             k_r;

  logic signed [W-1:0]  mul_x, mul_y;
  logic signed [PW-1:0] mul_p;
  logic [W-1:0]         mag_a, mag_b;
  logic [PW:0]          diff_abs;
  logic [W:0]           div_sh;
  logic [W+1:0]         div_trial;

  logic signed [W-1:0]  rn_w, rd_w;
  logic                 cmp_w, zd_w;
  logic                 b_zero, d_zero, sflip;
  logic signed [PW:0]   r_ab;
  logic [PW:0]          r_u;
  logic                 eq_w, diff_pos, diff_neg, e_pos, e_neg;

  always_comb begin
    case (cmd.mul_sel)
      rau_pkg::MSEL_AD: begin mul_x = a_r; mul_y = d_r; end
      rau_pkg::MSEL_BC: begin mul_x = b_r; mul_y = c_r; end
      rau_pkg::MSEL_AC: begin mul_x = a_r; mul_y = c_r; end
      default:          begin mul_x = b_r; mul_y = d_r; end
    endcase
  end
  assign mul_p = mul_x * mul_y;

  assign mag_a    = a_r[W-1] ? W'(-a_r) : W'(a_r);
  assign mag_b    = b_r[W-1] ? W'(-b_r) : W'(b_r);
  assign diff_abs = diff_r[PW] ? (PW+1)'(-diff_r) : (PW+1)'(diff_r);

  assign div_sh    = {rem_r[W-1:0], q_r[W-1]};
  assign div_trial = {1'b0, div_sh} - {2'b00, x_r};

  assign stat.act    = act_r;
  assign stat.a_zero = (a_r == '0);
  assign stat.b_zero = (b_r == '0);
  assign stat.gcd_eq = (x_r == y_r);

  // result selection
  always_comb begin
    b_zero   = (b_r == '0);
    d_zero   = (d_r == '0);
    sflip    = b_r[W-1] ^ d_r[W-1];
    r_ab     = sflip ? -(PW+1)'(p_ad_r) : (PW+1)'(p_ad_r);
    r_u      = r_ab;
    eq_w     = !r_ab[PW] && (acc_r <= AW'(r_u));
    diff_neg = diff_r[PW];
    diff_pos = !diff_r[PW] && (diff_r != '0);
    e_neg    = sflip ? diff_pos : diff_neg;
    e_pos    = sflip ? diff_neg : diff_pos;
    rn_w     = '0;
    rd_w     = '0;
    cmp_w    = 1'b0;
    zd_w     = 1'b0;
    if (act_r == rau_pkg::ACT_NEG || act_r == rau_pkg::ACT_SIMP) begin
      zd_w = b_zero;
    end else if (act_r <= rau_pkg::ACT_GE) begin
      zd_w = b_zero || d_zero;
    end
    case (act_r)
      rau_pkg::ACT_ADD: begin rn_w = W'(p_ad_r + p_bc_r); rd_w = W'(p_bd_r); end
      rau_pkg::ACT_SUB: begin rn_w = W'(p_ad_r - p_bc_r); rd_w = W'(p_bd_r); end
      rau_pkg::ACT_NEG: begin rn_w = -a_r; rd_w = b_r; end
      rau_pkg::ACT_MUL: begin rn_w = W'(p_ac_r); rd_w = W'(p_bd_r); end
      rau_pkg::ACT_DIV: begin rn_w = W'(p_ad_r); rd_w = W'(p_bc_r); end
      rau_pkg::ACT_SIMP: begin
        if (a_r == '0 && b_r == '0) begin
          rn_w = a_r;
          rd_w = b_r;
        end else if (a_r == '0) begin
          rn_w = '0;
          rd_w = b_r[W-1] ? '1 : W'(1);
        end else if (b_r == '0) begin
          rn_w = a_r[W-1] ? '1 : W'(1);
          rd_w = '0;
        end else begin
          rn_w = a_r[W-1] ? W'(-qn_r) : W'(qn_r);
          rd_w = b_r[W-1] ? W'(-q_r) : W'(q_r);
        end
      end
      rau_pkg::ACT_EQ: cmp_w = !zd_w && eq_w;
      rau_pkg::ACT_NE: cmp_w = !zd_w && !eq_w;
      rau_pkg::ACT_LT: cmp_w = !zd_w && e_neg;
      rau_pkg::ACT_LE: cmp_w = !zd_w && !e_pos;
      rau_pkg::ACT_GT: cmp_w = !zd_w && e_pos;
      rau_pkg::ACT_GE: cmp_w = !zd_w && !e_neg;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      rau_pkg::OP_LOAD: begin
        act_r <= in_action;
        a_r   <= in_a_num[W-1:0];
        b_r   <= in_a_den[W-1:0];
        c_r   <= in_b_num[W-1:0];
        d_r   <= in_b_den[W-1:0];
      end
      rau_pkg::OP_MUL: begin
        case (cmd.mul_sel)
          rau_pkg::MSEL_AD: p_ad_r <= mul_p;
          rau_pkg::MSEL_BC: p_bc_r <= mul_p;
          rau_pkg::MSEL_AC: p_ac_r <= mul_p;
          default:          p_bd_r <= mul_p;
        endcase
      end
      rau_pkg::OP_DIFF: begin
        diff_r <= (PW+1)'(p_ad_r) - (PW+1)'(p_bc_r);
        acc_r  <= '0;
      end
      rau_pkg::OP_SCALE: begin
        acc_r <= (acc_r << 1)
               + (rau_pkg::EQ_SCALE[cmd.scale_bit] ? AW'(diff_abs) : AW'(0));
      end
      rau_pkg::OP_GINIT: begin
        x_r <= mag_a;
        y_r <= mag_b;
        k_r <= '0;
      end
      rau_pkg::OP_GSTEP: begin
        if (!x_r[0] && !y_r[0]) begin
          x_r <= x_r >> 1;
          y_r <= y_r >> 1;
          k_r <= k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_r <= x_r >> 1;
        end else if (!y_r[0]) begin
          y_r <= y_r >> 1;
        end else if (x_r > y_r) begin
          x_r <= x_r - y_r;
        end else begin
          y_r <= y_r - x_r;
        end
      end
      rau_pkg::OP_DIV_LOAD_N: begin
        q_r   <= mag_a >> k_r;
        rem_r <= '0;
      end
      rau_pkg::OP_DIV_LOAD_D: begin
        qn_r  <= q_r;
        q_r   <= mag_b >> k_r;
        rem_r <= '0;
      end
      rau_pkg::OP_DIV_STEP: begin
        if (!div_trial[W+1]) begin
          rem_r <= div_trial[W:0];
          q_r   <= {q_r[W-2:0], 1'b1};
        end else begin
          rem_r <= div_sh;
          q_r   <= {q_r[W-2:0], 1'b0};
        end
      end
      rau_pkg::OP_FINISH: begin
        out_res_num      <= rau_pkg::FIELD_W'(rn_w);
        out_res_den      <= rau_pkg::FIELD_W'(rd_w);
        out_compare_true <= cmp_w;
        out_zero_den     <= zd_w;
      end
      default: ;
    endcase
  end

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rau_pkg::OP_GSTEP) |-> (x_r != '0 && y_r != '0))
    else $error("gcd step on a zero operand");

  a_cmp_zero_frac: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == rau_pkg::OP_FINISH && act_r >= rau_pkg::ACT_EQ)
    |=> (out_res_num == '0 && out_res_den == '0))
    else $error("nonzero fraction on a compare item");

endmodule
`default_nettype wire

>>> hdl/rau_ctrl.sv
// Controller: sequences load, products, compare scaling, gcd and division.
`timescale 1ns / 1ps
`default_nettype none
module rau_ctrl #(
  parameter int WORD_WIDTH = rau_pkg::WORD_WIDTH_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  wire               out_stall,
  input  rau_pkg::dp_stat_t stat,
  output rau_pkg::dp_cmd_t  cmd
);

  localparam int W     = WORD_WIDTH;
  localparam int CMAX  = (W > rau_pkg::EQ_BITS) ? W : rau_pkg::EQ_BITS;
  localparam int CNT_W = $clog2(CMAX + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_DIFF  = 9'b000000100,
    S_SCALE = 9'b000001000,
    S_GINIT = 9'b000010000,
    S_GCD   = 9'b000100000,
    S_DIVN  = 9'b001000000,
    S_DIVD  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd.op        = rau_pkg::OP_NONE;
    cmd.mul_sel   = '0;
    cmd.scale_bit = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = rau_pkg::OP_LOAD;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.op      = rau_pkg::OP_MUL;
        cmd.mul_sel = cnt_r[1:0];
        if (cnt_r == CNT_W'(3)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIFF;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIFF: begin
        cmd.op = rau_pkg::OP_DIFF;
        if (stat.act == rau_pkg::ACT_EQ || stat.act == rau_pkg::ACT_NE) begin
          state_nxt = S_SCALE;
        end else if (stat.act == rau_pkg::ACT_SIMP) begin
          state_nxt = S_GINIT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SCALE: begin
        cmd.op        = rau_pkg::OP_SCALE;
        cmd.scale_bit = rau_pkg::SIDX_W'(rau_pkg::EQ_BITS - 1)
                      - cnt_r[rau_pkg::SIDX_W-1:0];
        if (cnt_r == CNT_W'(rau_pkg::EQ_BITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_GINIT: begin
        cmd.op = rau_pkg::OP_GINIT;
        // a zero part needs no gcd: finish picks the fixed answer
        if (stat.a_zero || stat.b_zero) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.gcd_eq) begin
          cmd.op    = rau_pkg::OP_DIV_LOAD_N;
          cnt_nxt   = '0;
          state_nxt = S_DIVN;
        end else begin
          cmd.op = rau_pkg::OP_GSTEP;
        end
      end
      S_DIVN: begin
        if (cnt_r == CNT_W'(W)) begin
          cmd.op    = rau_pkg::OP_DIV_LOAD_D;
          cnt_nxt   = '0;
          state_nxt = S_DIVD;
        end else begin
          cmd.op  = rau_pkg::OP_DIV_STEP;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIVD: begin
        if (cnt_r == CNT_W'(W)) begin
          cnt_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          cmd.op  = rau_pkg::OP_DIV_STEP;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.op        = rau_pkg::OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_MUL))
    else $error("accepted item did not start the product sequence");

  a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside the finish step");

endmodule
`default_nettype wire

>>> dv/rau_checker.sv
// Result checker for the rational arithmetic unit: predicts every item and compares.
`timescale 1ns / 1ps
module rau_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire [3:0]         in_action,
  input  wire signed [31:0] in_a_num,
  input  wire signed [31:0] in_a_den,
  input  wire signed [31:0] in_b_num,
  input  wire signed [31:0] in_b_den,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire signed [31:0] out_res_num,
  input  wire signed [31:0] out_res_den,
  input  wire               out_compare_true,
  input  wire               out_zero_den,
  output int                fail_count,
  output int                pending,
  output int                results_seen
);

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        cmp;
    logic        zden;
  } rat_result_t;

  rat_result_t expected_results[$];

  function automatic logic [63:0] abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic rat_result_t compute_rational(logic [3:0] act, longint a, longint b,
                                                   longint c, longint d);
    rat_result_t r;
    logic [63:0] rn, rd, ma, mb, x, y, t, diff;
    longint ad, cb, sc, pa, pb, pc, pd, lhs, rhs;
    logic eq, res;
    r = '0;
    rn = 0;
    rd = 0;
    res = 0;
    if (act == rau_pkg::ACT_NEG || act == rau_pkg::ACT_SIMP) r.zden = (b == 0);
    else if (act <= rau_pkg::ACT_GE) r.zden = (b == 0 || d == 0);
    case (act)
      rau_pkg::ACT_ADD: begin rn = a * d + b * c; rd = b * d; end
      rau_pkg::ACT_SUB: begin rn = a * d - b * c; rd = b * d; end
      rau_pkg::ACT_NEG: begin rn = -a; rd = b; end
      rau_pkg::ACT_MUL: begin rn = a * c; rd = b * d; end
      rau_pkg::ACT_DIV: begin rn = a * d; rd = b * c; end
      rau_pkg::ACT_SIMP: begin
        ma = abs64(a);
        mb = abs64(b);
        if (ma == 0 && mb == 0) begin
          rn = a;
          rd = b;
        end else begin
          x = ma;
          y = mb;
          while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
          end
          rn = (a < 0) ? -(ma / x) : ma / x;
          rd = (b < 0) ? -(mb / x) : mb / x;
        end
      end
      default: begin
        if (act <= rau_pkg::ACT_GE && !r.zden) begin
          if (act == rau_pkg::ACT_EQ || act == rau_pkg::ACT_NE) begin
            ad = a * d;
            cb = c * b;
            diff = (ad >= cb) ? ad - cb : cb - ad;
            sc = a * longint'(abs64(d));
            if (b < 0) sc = -sc;
            eq = (sc >= 0) && (diff <= $unsigned(sc) / 64'd10000);
            res = (act == rau_pkg::ACT_EQ) ? eq : !eq;
          end else begin
            pa = a; pb = b; pc = c; pd = d;
            if (pb < 0) begin pa = -pa; pb = -pb; end
            if (pd < 0) begin pc = -pc; pd = -pd; end
            lhs = pa * pd;
            rhs = pc * pb;
            case (act)
              rau_pkg::ACT_LT: res = lhs < rhs;
              rau_pkg::ACT_LE: res = lhs <= rhs;
              rau_pkg::ACT_GT: res = lhs > rhs;
              default: res = lhs >= rhs;
            endcase
          end
        end
      end
    endcase
    if (act <= rau_pkg::ACT_SIMP) begin
      r.num = rn[31:0];
      r.den = rd[31:0];
    end
    r.cmp = res;
    return r;
  endfunction

  assign pending = expected_results.size();

  initial begin
    fail_count = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    rat_result_t e;
    if (rst_n && in_valid && !in_stall)
      expected_results.push_back(compute_rational(in_action, in_a_num, in_a_den,
                                                  in_b_num, in_b_den));
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_res_num !== e.num) begin
          $error("res_num expected %0d got %0d", $signed(e.num), out_res_num);
          fail_count++;
        end
        if (out_res_den !== e.den) begin
          $error("res_den expected %0d got %0d", $signed(e.den), out_res_den);
          fail_count++;
        end
        if (out_compare_true !== e.cmp) begin
          $error("compare_true expected %0b got %0b", e.cmp, out_compare_true);
          fail_count++;
        end
        if (out_zero_den !== e.zden) begin
          $error("zero_den expected %0b got %0b", e.zden, out_zero_den);
          fail_count++;
        end
      end
    end
  end
endmodule

>>> dv/tb_rational_arithmetic_unit.sv
// Testbench top for the rational arithmetic unit: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;

  localparam int IDLE_LIMIT = 20000;  // a full simplify item plus long stalls

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic out_stall = 0;
  logic [3:0] in_action = '0;
  logic signed [31:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  wire in_stall, out_valid, out_compare_true, out_zero_den;
  wire signed [31:0] out_res_num, out_res_den;
  int fail_count, pending, results_seen;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  rational_arithmetic_unit dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_a_num, .in_a_den,
    .in_b_num, .in_b_den, .out_valid, .out_stall, .out_res_num, .out_res_den,
    .out_compare_true, .out_zero_den
  );

  rau_checker checker_i (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_a_num, .in_a_den,
    .in_b_num, .in_b_den, .out_valid, .out_stall, .out_res_num, .out_res_den,
    .out_compare_true, .out_zero_den, .fail_count, .pending, .results_seen
  );

  // receiver stall, redrawn each falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog: cycles with no accepted item on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // random operand: edges of the range often, small values sometimes, else full random
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return 32'hffff_ffff;
      4, 5: return $urandom_range(200) - 100;
      6: return $urandom_range(70000) - 35000;
      default: return $urandom;
    endcase
  endfunction

  // present one item, hold it until accepted; valid stays up for the next one
  task automatic send_item(logic [3:0] act, logic [31:0] a, logic [31:0] b,
                           logic [31:0] c, logic [31:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_action <= act;
    in_a_num <= a;
    in_a_den <= b;
    in_b_num <= c;
    in_b_den <= d;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    logic [31:0] a, b;
    for (int i = 0; i < count; i++) begin
      a = pick_operand();
      b = pick_operand();
      // near-equal pairs make eq/ne interesting
      if ($urandom_range(3) == 0)
        send_item(4'($urandom_range(15)), a, b, a + $urandom_range(2) - 1, b);
      else
        send_item(4'($urandom_range(15)), a, b, pick_operand(), pick_operand());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    // directed: every action, edges, zero denominators, simplify corners
    for (int op = 0; op < 16; op++) send_item(4'(op), 3, 4, -5, 6);
    send_item(rau_pkg::ACT_SIMP, 0, 0, 1, 1);
    send_item(rau_pkg::ACT_SIMP, 0, -12, 0, 0);
    send_item(rau_pkg::ACT_SIMP, -12, 0, 0, 0);
    send_item(rau_pkg::ACT_SIMP, 32'h8000_0000, 32'h8000_0000, 0, 0);
    send_item(rau_pkg::ACT_EQ, -1, 3, -1, 3);
    send_item(rau_pkg::ACT_EQ, 10000, 1, 10001, 1);
    send_item(rau_pkg::ACT_LT, 1, 0, 1, 1);
    send_item(rau_pkg::ACT_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
              32'h7fff_ffff);
    send_item(rau_pkg::ACT_GE, 32'h8000_0000, -1, 32'h7fff_ffff, 1);
    send_random(50);
    in_valid <= 0;
    // hold off until the block has drained
    while (pending != 0) @(negedge clk);
    send_idle_pct = 26;
    recv_idle_pct = 83;
    send_random(300);
    send_idle_pct = 83;
    recv_idle_pct = 26;
    send_random(300);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(350);
    in_valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Covered %0d items and %0d results: all actions, undefined codes,",
             items_sent, results_seen);
    $display("zero denominators, simplify corners and extreme operands.");
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
